>>> rtl/ssc_pkg.sv
// Package for the servo status packet checker.
// Holds the payload and configuration structs, result codes and shared constants.
// No dependencies.
package ssc_pkg;

  localparam int FRAME_BUFFER_BYTES = 64;

  // Output queue depth: room for two results per request plus slack.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0] PosMax = 7'd127;

  localparam logic [3:0] CFG_SERVO_ID      = 4'd0;
  localparam logic [3:0] CFG_DATA_COUNT    = 4'd1;
  localparam logic [3:0] CFG_HEADER_FIRST  = 4'd2;
  localparam logic [3:0] CFG_HEADER_SECOND = 4'd3;

  localparam logic [7:0] SERVO_ID_RESET      = 8'd1;
  localparam logic [5:0] DATA_COUNT_RESET    = 6'd0;
  localparam logic [7:0] HEADER_FIRST_RESET  = 8'd255;
  localparam logic [7:0] HEADER_SECOND_RESET = 8'd255;

  typedef enum logic [2:0] {
    RES_OK       = 3'd0,
    RES_HEADER   = 3'd1,
    RES_ID       = 3'd2,
    RES_LENGTH   = 3'd3,
    RES_CHECKSUM = 3'd4,
    RES_SHORT    = 3'd5
  } result_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic       item_kind;
    logic [5:0] data_index;
    logic [7:0] data_byte;
    logic [7:0] status_byte;
    result_e    result_code;
    logic       last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [7:0] servo_id;
    logic [5:0] data_count;
    logic [7:0] header_first;
    logic [7:0] header_second;
  } cfg_t;

  // Results produced by one request, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } results_t;

endpackage

>>> rtl/servo_status_packet_checker_top.sv
// Servo status packet checker, top level: configuration registers, input register,
// frame checker and result queue. Depends on ssc_pkg, ssc_frame_check, ssc_out_queue.
// A result passes the input register and then the result queue before it is offered.
// Throughput: one byte per cycle while the queue has room for its results; the queue
// drains one result per cycle, so a data byte that ends a frame pushes two results.
// Reset: asynchronous, active low; clears frame state and queue, registers to defaults.
module servo_status_packet_checker_top #(
  parameter int FrameBufferBytes = ssc_pkg::FRAME_BUFFER_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ssc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ssc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import ssc_pkg::*;

  cfg_t             cfg_q;
  logic             in_valid_q;
  in_item_t         in_q;
  results_t         results;
  logic [QCntW-1:0] space;
  logic             advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_id      <= SERVO_ID_RESET;
      cfg_q.data_count    <= DATA_COUNT_RESET;
      cfg_q.header_first  <= HEADER_FIRST_RESET;
      cfg_q.header_second <= HEADER_SECOND_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SERVO_ID:      cfg_q.servo_id      <= cfg_data_i;
        CFG_DATA_COUNT:    cfg_q.data_count    <= cfg_data_i[5:0];
        CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_data_i;
        CFG_HEADER_SECOND: cfg_q.header_second <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The registered byte moves on once the queue can hold all of its results.
  assign advance    = in_valid_q && (QCntW'(results.count) <= space);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  ssc_frame_check #(
    .FrameBufferBytes(FrameBufferBytes)
  ) u_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .results_o(results)
  );

  ssc_out_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_en_i  (advance),
    .push_i     (results),
    .pop_i      (out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_data_o),
    .space_o    (space)
  );

  a_space_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    space <= QCntW'(QDepth))
    else $error("result queue space out of range");

  a_stalled_byte_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("stalled input byte was lost or changed");

  a_frame_end_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.frame_end |-> results.count != 2'd0)
    else $error("frame end produced no verdict");

endmodule

>>> rtl/ssc_frame_check.sv
// Frame state and per-byte checks of the servo status packet checker.
// Depends on ssc_pkg.
module ssc_frame_check #(
  parameter int FrameBufferBytes = ssc_pkg::FRAME_BUFFER_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ssc_pkg::in_item_t item_i,
  input  ssc_pkg::cfg_t     cfg_i,
  output ssc_pkg::results_t results_o
);
  import ssc_pkg::*;

  logic [6:0] pos_q, pos_d;
  logic [7:0] sum_q, sum_d;
  result_e    fail_q, fail_d;
  logic [7:0] status_q, status_d;
  logic       cks_seen_q, cks_seen_d;

  logic [7:0] b;
  logic [6:0] cks_pos;
  logic       in_buf;
  logic       data_hit;
  result_e    fail_new;
  out_item_t  data_item;
  out_item_t  verdict_item;

  always_comb begin
    b        = item_i.rx_byte;
    cks_pos  = 7'd5 + {1'b0, cfg_i.data_count};
    in_buf   = int'(pos_q) < FrameBufferBytes;
    sum_d    = sum_q;
    status_d = status_q;
    cks_seen_d = cks_seen_q;
    fail_new = RES_OK;
    data_hit = 1'b0;

    if (in_buf && !cks_seen_q) begin
      if (pos_q == 7'd0) begin
        if (b != cfg_i.header_first) fail_new = RES_HEADER;
      end else if (pos_q == 7'd1) begin
        if (b != cfg_i.header_second) fail_new = RES_HEADER;
      end else if (pos_q == 7'd2) begin
        sum_d = b;
        if (b != cfg_i.servo_id) fail_new = RES_ID;
      end else if (pos_q == 7'd3) begin
        sum_d = sum_q + b;
        if (b != {2'b00, cfg_i.data_count} + 8'd2) fail_new = RES_LENGTH;
      end else if (pos_q == 7'd4) begin
        sum_d    = sum_q + b;
        status_d = b;
      end else if (pos_q < cks_pos) begin
        sum_d    = sum_q + b;
        data_hit = 1'b1;
      end else if (pos_q == cks_pos) begin
        if (b != ~sum_q) fail_new = RES_CHECKSUM;
        cks_seen_d = 1'b1;
      end
    end

    // The first failure found in arrival order is the one kept.
    fail_d = (fail_q == RES_OK) ? fail_new : fail_q;
    pos_d  = (pos_q == PosMax) ? pos_q : pos_q + 7'd1;

    data_item               = '0;
    data_item.item_kind     = 1'b0;
    data_item.data_index    = 6'(pos_q - 7'd5);
    data_item.data_byte     = b;
    data_item.result_code   = RES_OK;

    verdict_item               = '0;
    verdict_item.item_kind     = 1'b1;
    verdict_item.status_byte   = status_d;
    verdict_item.result_code   = (fail_d == RES_OK && !cks_seen_d) ? RES_SHORT : fail_d;
    verdict_item.last_of_frame = 1'b1;

    results_o = '0;
    if (data_hit) begin
      results_o.first  = data_item;
      results_o.second = verdict_item;
      results_o.count  = item_i.frame_end ? 2'd2 : 2'd1;
    end else if (item_i.frame_end) begin
      results_o.first = verdict_item;
      results_o.count = 2'd1;
    end

    if (item_i.frame_end) begin
      pos_d      = '0;
      sum_d      = '0;
      fail_d     = RES_OK;
      status_d   = '0;
      cks_seen_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      fail_q     <= RES_OK;
      status_q   <= '0;
      cks_seen_q <= 1'b0;
    end else if (en_i) begin
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      fail_q     <= fail_d;
      status_q   <= status_d;
      cks_seen_q <= cks_seen_d;
    end
  end

endmodule

>>> rtl/ssc_out_queue.sv
// Result queue of the servo status packet checker; takes up to two results a cycle.
// Depends on ssc_pkg.
module ssc_out_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_en_i,
  input  ssc_pkg::results_t          push_i,
  input  logic                       pop_i,
  output logic                       out_valid_o,
  output ssc_pkg::out_item_t         out_item_o,
  output logic [ssc_pkg::QCntW-1:0]  space_o
);
  import ssc_pkg::*;

  out_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QCntW-1:0] push_cnt;
  logic             do_pop;

  assign do_pop      = pop_i && (cnt_q != '0);
  assign out_valid_o = cnt_q != '0;
  assign out_item_o  = mem_q[rd_ptr_q];
  // Space counts the slot freed by a pop in this same cycle.
  assign space_o     = QCntW'(QDepth) - cnt_q + QCntW'(do_pop);

  always_comb begin
    push_cnt = push_en_i ? QCntW'(push_i.count) : '0;
    wr_ptr_d = wr_ptr_q + QPtrW'(push_cnt);
    rd_ptr_d = rd_ptr_q + QPtrW'(do_pop);
    cnt_d    = cnt_q + push_cnt - QCntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_en_i && push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_en_i && push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + QPtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
